[rtl/hsmt_pkg.sv]
// Shared types and constants of the hashed set-associative move table.
package hsmt_pkg;

   localparam int KEY_W = 64;
   localparam int SQ_W = 8;
   localparam int CNT_W = 8;

   localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
   localparam int FMIX_SHIFT = 33;

   typedef enum logic [1:0] {
      OP_PROBE = 2'd0,
      OP_STORE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MIX,
      ST_READ,
      ST_LOOKUP,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   // Mixing sequence: parts 0..2 build one 64-bit product, part 3 folds it.
   localparam logic [1:0] MIX_FOLD = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [SQ_W-1:0]   sq_from;
      logic [SQ_W-1:0]   sq_to;
      logic [KEY_W-1:0]  captured;
      logic [CNT_W-1:0]  taken_count;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef struct packed {
      logic       load;
      logic       mix;
      logic [1:0] mix_part;
      logic       mix_const;
      logic       rd;
      logic       lookup;
      logic       sweep_wr;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type req_op;
      logic   sweep_last;
   } status_type;

endpackage

[rtl/hsmt_if.sv]
// Valid/ready channel interfaces for request and response items.
interface hsmt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] position_key;
   logic [7:0]  move_from;
   logic [7:0]  move_to;
   logic [63:0] move_captured;
   logic [7:0]  move_capture_count;

   modport source (output valid, operation, position_key, move_from, move_to,
                   move_captured, move_capture_count, input ready);
   modport sink (input valid, operation, position_key, move_from, move_to,
                 move_captured, move_capture_count, output ready);
endinterface

interface hsmt_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [7:0]  found_from;
   logic [7:0]  found_to;
   logic [63:0] found_captured;
   logic [7:0]  found_capture_count;

   modport source (output valid, hit, found_from, found_to, found_captured,
                   found_capture_count, input ready);
   modport sink (input valid, hit, found_from, found_to, found_captured,
                 found_capture_count, output ready);
endinterface

[rtl/hsmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hsmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/hsmt_dp.sv]
// Datapath: key mixing on a shared 32x32 multiplier, bucket lookup and result registers.
module hsmt_dp
   import hsmt_pkg::*;
#(
   parameter int BUCKET_COUNT = 64,
   parameter int WAYS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic [1:0]       req_operation,
   input  logic [63:0]      req_position_key,
   input  logic [7:0]       req_move_from,
   input  logic [7:0]       req_move_to,
   input  logic [63:0]      req_move_captured,
   input  logic [7:0]       req_move_capture_count,
   output logic             rsp_hit,
   output logic [7:0]       rsp_found_from,
   output logic [7:0]       rsp_found_to,
   output logic [63:0]      rsp_found_captured,
   output logic [7:0]       rsp_found_capture_count
);

   localparam int IDX_BITS = $clog2(BUCKET_COUNT);
   localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W = WAYS * SLOT_W;
   localparam logic [IDX_BITS-1:0] BUCKET_MASK = IDX_BITS'(BUCKET_COUNT - 1);
   localparam logic [WAY_BITS-1:0] WAY_MASK = WAY_BITS'(WAYS - 1);

   op_type             op_ff;
   slot_type           item_ff;
   logic [63:0]        x_ff, x_in;
   logic [63:0]        acc_ff, acc_in;
   logic [IDX_BITS-1:0] sweep_ff, sweep_in;
   logic               res_hit_ff, res_hit_in;
   slot_type           res_slot_ff, res_slot_in;
   logic               out_hit_ff;
   slot_type           out_slot_ff;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod, const_sel;
   logic [IDX_BITS-1:0] bucket;
   logic [WAY_BITS-1:0] fallback_way, store_way, hit_way;
   logic               any_hit, any_free;
   slot_type [WAYS-1:0] row_rd, row_wr;
   logic [ROW_W-1:0]   ram_rd_data, ram_wr_data;
   logic               ram_wr_en;
   logic [IDX_BITS-1:0] ram_wr_addr;

   assign bucket = x_ff[IDX_BITS-1:0] & BUCKET_MASK;
   assign fallback_way = x_ff[IDX_BITS +: WAY_BITS] & WAY_MASK;

   // Low 64 bits of x * C from three 32-bit partial products.
   always_comb begin
      const_sel = cmd.mix_const ? FMIX_C2 : FMIX_C1;
      mul_a = (cmd.mix_part == 2'd1) ? x_ff[63:32] : x_ff[31:0];
      mul_b = (cmd.mix_part == 2'd2) ? const_sel[63:32] : const_sel[31:0];
      prod = mul_a * mul_b;
   end

   always_comb begin
      x_in = x_ff;
      acc_in = acc_ff;
      if (cmd.load) begin
         x_in = req_position_key ^ (req_position_key >> FMIX_SHIFT);
      end else if (cmd.mix) begin
         case (cmd.mix_part)
            2'd0: acc_in = prod;
            MIX_FOLD: x_in = acc_ff ^ (acc_ff >> FMIX_SHIFT);
            default: acc_in = acc_ff + {prod[31:0], 32'd0};
         endcase
      end
   end

   // Bucket search: first valid matching slot for a probe, first free or matching for a store.
   always_comb begin
      row_rd = ram_rd_data;
      any_hit = 1'b0;
      any_free = 1'b0;
      hit_way = '0;
      store_way = fallback_way;
      for (int w = 0; w < WAYS; w++) begin
         if (!any_hit && row_rd[w].valid && row_rd[w].key == item_ff.key) begin
            any_hit = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (!any_free && (!row_rd[w].valid || row_rd[w].key == item_ff.key)) begin
            any_free = 1'b1;
            store_way = WAY_BITS'(w);
         end
      end
      row_wr = row_rd;
      row_wr[store_way] = item_ff;
   end

   always_comb begin
      ram_wr_en = 1'b0;
      ram_wr_addr = bucket;
      ram_wr_data = row_wr;
      if (cmd.sweep_wr) begin
         ram_wr_en = 1'b1;
         ram_wr_addr = sweep_ff;
         ram_wr_data = '0;
      end else if (cmd.lookup && op_ff == OP_STORE) begin
         ram_wr_en = 1'b1;
      end
   end

   hsmt_ram #(
      .WIDTH(ROW_W),
      .DEPTH(BUCKET_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.rd),
      .rd_addr(bucket),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      res_hit_in = res_hit_ff;
      res_slot_in = res_slot_ff;
      if (cmd.load) begin
         res_hit_in = 1'b0;
         res_slot_in = '0;
      end else if (cmd.lookup && op_ff == OP_PROBE && any_hit) begin
         res_hit_in = 1'b1;
         res_slot_in = row_rd[hit_way];
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_wr) begin
         sweep_in = status.sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_operation);
         item_ff <= '{valid: 1'b1, key: req_position_key, sq_from: req_move_from,
                      sq_to: req_move_to, captured: req_move_captured,
                      taken_count: req_move_capture_count};
      end
      x_ff <= x_in;
      acc_ff <= acc_in;
      res_hit_ff <= res_hit_in;
      res_slot_ff <= res_slot_in;
      if (cmd.rsp_load) begin
         out_hit_ff <= res_hit_ff;
         out_slot_ff <= res_slot_ff;
      end
   end

   assign status.req_op = op_type'(req_operation);
   assign status.sweep_last = (sweep_ff == IDX_BITS'(BUCKET_COUNT - 1));

   assign rsp_hit = out_hit_ff;
   assign rsp_found_from = out_slot_ff.sq_from;
   assign rsp_found_to = out_slot_ff.sq_to;
   assign rsp_found_captured = out_slot_ff.captured;
   assign rsp_found_capture_count = out_slot_ff.taken_count;

endmodule

[rtl/hsmt_ctrl.sv]
// Controller: sequences mixing, lookup, clearing sweeps and the response handshake.
module hsmt_ctrl
   import hsmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [2:0] mix_cnt_ff, mix_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         mix_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mix_cnt_ff <= mix_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mix_cnt_in = mix_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd = '0;
      cmd.mix_part = mix_cnt_ff[1:0];
      cmd.mix_const = mix_cnt_ff[2];
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               mix_cnt_in = '0;
               case (status.req_op)
                  OP_PROBE, OP_STORE: state_in = ST_MIX;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_MIX: begin
            cmd.mix = 1'b1;
            mix_cnt_in = mix_cnt_ff + 1'b1;
            if (mix_cnt_ff == 3'd7) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd = 1'b1;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in = ST_FINISH;
         end
         ST_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // The result waits here only while the output register still holds an older one.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_mix_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && mix_cnt_ff == 3'd7) |=> state_ff == ST_READ)
      else $error("mixing did not end after eight steps");

   a_lookup_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> $past(state_ff) == ST_READ)
      else $error("lookup without a preceding bucket read");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_CLEAR && state_ff == ST_FINISH) |-> $past(status.sweep_last))
      else $error("clear finished before sweeping every bucket");

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !rsp_valid_ff)
      else $error("response offered during the initial clearing pass");

endmodule

[rtl/hashed_set_assoc_move_table_top.sv]
// Top level of the hashed set-associative move table.
//
//  channel  port    dir  contents
//  request  req_ch  in   operation, position_key and the four move fields
//  response rsp_ch  out  hit and the four found move fields
//
// After acceptance a probe or store item passes through key mixing on one shared
// 32x32 multiplier (three partial products and a fold per constant), a bucket read,
// a compare/write-back step and the output load.
// A clear writes one bucket row per cycle.
// After reset a clearing pass over every bucket runs with req_ch.ready low.
// The next item is accepted while a result still waits in the output register.
module hashed_set_assoc_move_table_top
   import hsmt_pkg::*;
#(
   parameter int BUCKET_COUNT = 64,
   parameter int WAYS = 4
) (
   input  logic       clock,
   input  logic       reset,
   hsmt_req_if.sink   req_ch,
   hsmt_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   hsmt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .cmd      (cmd)
   );

   hsmt_dp #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .WAYS        (WAYS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_ch.operation),
      .req_position_key       (req_ch.position_key),
      .req_move_from          (req_ch.move_from),
      .req_move_to            (req_ch.move_to),
      .req_move_captured      (req_ch.move_captured),
      .req_move_capture_count (req_ch.move_capture_count),
      .rsp_hit                (rsp_ch.hit),
      .rsp_found_from         (rsp_ch.found_from),
      .rsp_found_to           (rsp_ch.found_to),
      .rsp_found_captured     (rsp_ch.found_captured),
      .rsp_found_capture_count(rsp_ch.found_capture_count)
   );

endmodule

[bench/move_table_monitor.sv]
// Watches the request and response channels, predicts each answer and checks it.
`timescale 1ns / 1ps

module move_table_monitor
   import hsmt_pkg::*;
#(
   parameter int BUCKET_COUNT = 64,
   parameter int WAYS = 4
) (
   input  logic  clock,
   input  logic  reset,
   hsmt_req_if   req_ch,
   hsmt_rsp_if   rsp_ch,
   output int    pending_count,
   output int    mismatch_count
);

   localparam int SLOT_COUNT = BUCKET_COUNT * WAYS;
   localparam int INDEX_BITS = $clog2(BUCKET_COUNT);

   typedef struct {
      logic              hit;
      logic [SQ_W-1:0]   sq_from;
      logic [SQ_W-1:0]   sq_to;
      logic [KEY_W-1:0]  captured;
      logic [CNT_W-1:0]  taken_count;
   } move_answer_type;

   logic             tbl_valid [SLOT_COUNT];
   logic [KEY_W-1:0] tbl_key [SLOT_COUNT];
   logic [SQ_W-1:0]  tbl_from [SLOT_COUNT];
   logic [SQ_W-1:0]  tbl_to [SLOT_COUNT];
   logic [KEY_W-1:0] tbl_captured [SLOT_COUNT];
   logic [CNT_W-1:0] tbl_count [SLOT_COUNT];

   move_answer_type awaited_answers[$];
   int errors = 0;

   function automatic logic [63:0] mix_key(logic [63:0] k);
      k = k ^ (k >> FMIX_SHIFT);
      k = k * FMIX_C1;
      k = k ^ (k >> FMIX_SHIFT);
      k = k * FMIX_C2;
      return k ^ (k >> FMIX_SHIFT);
   endfunction

   // Applies one operation to the shadow table and returns the answer it must give.
   function automatic move_answer_type apply_table_op(op_type op, logic [63:0] key,
                                                      logic [7:0] sq_from, logic [7:0] sq_to,
                                                      logic [63:0] captured,
                                                      logic [7:0] taken_count);
      move_answer_type ans;
      logic [63:0] mixed;
      int base;
      int way;
      bit found;
      ans = '{1'b0, '0, '0, '0, '0};
      mixed = mix_key(key);
      base = int'(mixed & (BUCKET_COUNT - 1)) * WAYS;
      found = 1'b0;
      case (op)
         OP_PROBE: begin
            for (int s = 0; s < WAYS; s++) begin
               if (!found && tbl_valid[base + s] && tbl_key[base + s] == key) begin
                  found = 1'b1;
                  ans = '{1'b1, tbl_from[base + s], tbl_to[base + s],
                          tbl_captured[base + s], tbl_count[base + s]};
               end
            end
         end
         OP_STORE: begin
            // A full bucket without the key gives up the slot named by the bits above the index.
            way = int'((mixed >> INDEX_BITS) & (WAYS - 1));
            for (int s = 0; s < WAYS; s++) begin
               if (!found && (!tbl_valid[base + s] || tbl_key[base + s] == key)) begin
                  found = 1'b1;
                  way = s;
               end
            end
            tbl_valid[base + way] = 1'b1;
            tbl_key[base + way] = key;
            tbl_from[base + way] = sq_from;
            tbl_to[base + way] = sq_to;
            tbl_captured[base + way] = captured;
            tbl_count[base + way] = taken_count;
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
         end
         default: ;
      endcase
      return ans;
   endfunction

   function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      move_answer_type want;
      if (reset) begin
         awaited_answers.delete();
         for (int i = 0; i < SLOT_COUNT; i++) tbl_valid[i] = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_answers.size() == 0) begin
               $error("response item arrived with no request waiting for it");
               errors++;
            end else begin
               want = awaited_answers.pop_front();
               errors += field_differs("hit", 64'(want.hit), 64'(rsp_ch.hit));
               errors += field_differs("found_from", 64'(want.sq_from),
                                       64'(rsp_ch.found_from));
               errors += field_differs("found_to", 64'(want.sq_to), 64'(rsp_ch.found_to));
               errors += field_differs("found_captured", want.captured, rsp_ch.found_captured);
               errors += field_differs("found_capture_count", 64'(want.taken_count),
                                       64'(rsp_ch.found_capture_count));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited_answers.push_back(apply_table_op(op_type'(req_ch.operation),
                                                     req_ch.position_key, req_ch.move_from,
                                                     req_ch.move_to, req_ch.move_captured,
                                                     req_ch.move_capture_count));
         end
      end
      pending_count <= awaited_answers.size();
      mismatch_count <= errors;
   end

endmodule

[bench/hashed_set_assoc_move_table_top_tb.sv]
// Stimulus, clock, reset and verdict for the hashed set-associative move table.
`timescale 1ns / 1ps

module hashed_set_assoc_move_table_top_tb
   import hsmt_pkg::*;
();

   localparam int BUCKET_COUNT = 64;
   localparam int WAYS = 4;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CALM_ITEMS = 200;
   localparam int POOL_SIZE = 384;
   localparam int CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic calm;
   int   cycle_count = 0;
   int   pending_count;
   int   mismatch_count;
   logic [63:0] key_pool [POOL_SIZE];

   hsmt_req_if req_ch ();
   hsmt_rsp_if rsp_ch ();

   hashed_set_assoc_move_table_top #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .WAYS(WAYS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   move_table_monitor #(
      .BUCKET_COUNT(BUCKET_COUNT),
      .WAYS(WAYS)
   ) monitor (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .pending_count(pending_count),
      .mismatch_count(mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: ready drops for short random bursts unless the run has gone calm.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= (stall_left == 0);
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 4);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one item and returns at the edge that accepts it; valid stays high afterwards.
   task automatic send_item(op_type op, logic [63:0] key, logic [7:0] sq_from,
                            logic [7:0] sq_to, logic [63:0] captured,
                            logic [7:0] taken_count);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.position_key <= key;
      req_ch.move_from <= sq_from;
      req_ch.move_to <= sq_to;
      req_ch.move_captured <= captured;
      req_ch.move_capture_count <= taken_count;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      op_type op;
      int pick;
      logic [63:0] key;
      reset <= 1'b1;
      calm <= 1'b0;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_PROBE;
      req_ch.position_key <= '0;
      req_ch.move_from <= '0;
      req_ch.move_to <= '0;
      req_ch.move_captured <= '0;
      req_ch.move_capture_count <= '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extreme keys and moves, overwrite, unused code, clear.
      send_item(OP_PROBE, '0, '0, '0, '0, '0);
      send_item(OP_NONE, '1, '1, '1, '1, '1);
      send_item(OP_STORE, '0, '0, '0, '0, '0);
      send_item(OP_STORE, '1, '1, '1, '1, '1);
      send_item(OP_PROBE, '0, '1, '1, '1, '1);
      send_item(OP_PROBE, '1, '0, '0, '0, '0);
      send_item(OP_STORE, '0, 8'h5a, 8'ha5, 64'h00ff00ff00ff00ff, 8'h81);
      send_item(OP_PROBE, '0, '0, '0, '0, '0);
      send_item(OP_NONE, '1, '0, '0, '0, '0);
      send_item(OP_PROBE, '1, '0, '0, '0, '0);
      send_item(OP_CLEAR, '1, '1, '1, '1, '1);
      send_item(OP_PROBE, '0, '0, '0, '0, '0);
      send_item(OP_PROBE, '1, '0, '0, '0, '0);
      for (int i = 2; i < 8; i++) begin
         send_item(OP_STORE, key_pool[i], pick_byte(), pick_byte(), pick_word(), pick_byte());
      end
      for (int i = 2; i < 8; i++) send_item(OP_PROBE, key_pool[i], '0, '0, '0, '0);
      wait_for_drain();

      // Random part: a limited key pool so buckets overflow and probes often hit.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= RANDOM_ITEMS - CALM_ITEMS);
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         pick = $urandom_range(0, 999);
         if (pick < 2) op = OP_CLEAR;
         else if (pick < 32) op = OP_NONE;
         else if (pick < 520) op = OP_STORE;
         else op = OP_PROBE;
         if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else key = {$urandom, $urandom};
         send_item(op, key, pick_byte(), pick_byte(), pick_word(), pick_byte());
      end

      wait_for_drain();
      repeat (BUCKET_COUNT + 16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
